// ===== rtl/lsbse_pkg.sv =====
// shared constants and types for the lsb stego payload extractor
`default_nettype none
package lsbse_pkg;

	localparam int HEADER_BYTES    = 54;
	localparam int HDR_W           = 11;
	localparam int MAGIC_MAX_CHARS = 8;
	localparam int LEN_BITS        = 32;
	localparam int CHR_BITS        = 8;
	localparam int BIF_W           = 6;
	localparam int MLEN_W          = 4;
	localparam int MWORD_W         = 64;
	localparam int CFG_IDX_W       = 1;
	localparam int FIFO_DEPTH      = 4;
	localparam int PTR_W           = 2;
	localparam int CNT_W           = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 1'b1;

	typedef enum logic [2:0] {
		KIND_MAGIC_OK  = 3'd0,
		KIND_MAGIC_BAD = 3'd1,
		KIND_EXT_CHAR  = 3'd2,
		KIND_PAY_BYTE  = 3'd3,
		KIND_PAY_END   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [CHR_BITS-1:0] value;
		logic                last;
	} res_t;

endpackage : lsbse_pkg
`default_nettype wire

// ===== rtl/lsbse_front.sv =====
// front end: configuration registers and the field parser that classifies each carrier beat
`default_nettype none
module lsbse_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lsbse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsbse_pkg::MWORD_W-1:0]    cfg_data,
	input  wire logic                             accept,
	input  wire logic [lsbse_pkg::CHR_BITS-1:0]   carrier_byte,
	input  wire logic                             frame_start,
	output logic                                  push,
	output lsbse_pkg::res_t                       res
);
	import lsbse_pkg::*;

	typedef enum logic [3:0] {
		PH_HEADER = 4'd0,
		PH_MLEN   = 4'd1,
		PH_MCHR   = 4'd2,
		PH_ELEN   = 4'd3,
		PH_ECHR   = 4'd4,
		PH_PLEN   = 4'd5,
		PH_PDAT   = 4'd6,
		PH_END    = 4'd7,
		PH_IDLE   = 4'd8
	} phase_t;

	logic [MWORD_W-1:0]  magic_word_q;
	logic [MLEN_W-1:0]   magic_len_q;
	phase_t              phase_q, phase_d;
	logic [BIF_W-1:0]    bif_q, bif_d;
	logic [HDR_W-1:0]    hl_q, hl_d;
	logic [LEN_BITS-1:0] acc_q, acc_d;
	logic [LEN_BITS-1:0] items_q, items_d;
	logic [MLEN_W-1:0]   midx_q, midx_d;
	logic                meq_q, meq_d;
	logic                emit;
	res_t                res_d;

	always_comb begin
		logic [LEN_BITS-1:0] v;
		logic [BIF_W-1:0]    need;
		logic [5:0]          sh;
		logic [CHR_BITS-1:0] want;
		logic                go;
		// restart applies before the beat is handled
		phase_d = frame_start ? PH_HEADER : phase_q;
		bif_d   = frame_start ? '0 : bif_q;
		hl_d    = frame_start ? HDR_W'(HEADER_BYTES) : hl_q;
		acc_d   = frame_start ? '0 : acc_q;
		items_d = frame_start ? '0 : items_q;
		midx_d  = frame_start ? '0 : midx_q;
		meq_d   = frame_start ? 1'b1 : meq_q;
		emit    = 1'b0;
		res_d   = '{kind: KIND_MAGIC_OK, value: '0, last: 1'b0};
		v       = '0;
		need    = '0;
		sh      = '0;
		want    = '0;
		go      = 1'b0;

		if (phase_d == PH_END) begin
			phase_d = PH_IDLE;
			emit    = 1'b1;
			res_d   = '{kind: KIND_PAY_END, value: '0, last: 1'b1};
		end else if (phase_d == PH_HEADER) begin
			if (hl_d != '0) begin
				hl_d = hl_d - HDR_W'(1);
				if (hl_d == '0)
					phase_d = PH_MLEN;
			end else begin
				phase_d = PH_MLEN;
				go      = 1'b1;
			end
		end else if (phase_d != PH_IDLE) begin
			go = 1'b1;
		end

		if (go) begin
			acc_d = {acc_d[LEN_BITS-2:0], carrier_byte[0]};
			bif_d = bif_d + BIF_W'(1);
			need  = (phase_d == PH_MLEN || phase_d == PH_ELEN || phase_d == PH_PLEN)
				? BIF_W'(LEN_BITS) : BIF_W'(CHR_BITS);
			if (bif_d >= need) begin
				v     = acc_d;
				acc_d = '0;
				bif_d = '0;
				unique case (phase_d)
					PH_MLEN: begin
						if (v[LEN_BITS-1] || v != LEN_BITS'(magic_len_q)
							|| magic_len_q > MLEN_W'(MAGIC_MAX_CHARS)) begin
							phase_d = PH_IDLE;
							emit    = 1'b1;
							res_d   = '{kind: KIND_MAGIC_BAD, value: '0, last: 1'b1};
						end else if (v == '0) begin
							phase_d = PH_ELEN;
							emit    = 1'b1;
						end else begin
							items_d = v;
							midx_d  = '0;
							meq_d   = 1'b1;
							phase_d = PH_MCHR;
						end
					end
					PH_MCHR: begin
						// first character sits in the top byte of the word
						sh   = 6'd56 - {midx_d[2:0], 3'b000};
						want = CHR_BITS'(magic_word_q >> sh);
						if (v[CHR_BITS-1:0] != want)
							meq_d = 1'b0;
						midx_d  = midx_d + MLEN_W'(1);
						items_d = items_d - LEN_BITS'(1);
						if (items_d == '0) begin
							emit = 1'b1;
							if (meq_d) begin
								phase_d = PH_ELEN;
							end else begin
								phase_d = PH_IDLE;
								res_d   = '{kind: KIND_MAGIC_BAD, value: '0, last: 1'b1};
							end
						end
					end
					PH_ELEN: begin
						items_d = v[LEN_BITS-1] ? '0 : v;
						phase_d = (items_d == '0) ? PH_PLEN : PH_ECHR;
					end
					PH_ECHR: begin
						items_d = items_d - LEN_BITS'(1);
						if (items_d == '0)
							phase_d = PH_PLEN;
						emit  = 1'b1;
						res_d = '{kind: KIND_EXT_CHAR, value: v[CHR_BITS-1:0], last: 1'b0};
					end
					PH_PLEN: begin
						items_d = v[LEN_BITS-1] ? '0 : v;
						if (items_d == '0) begin
							phase_d = PH_IDLE;
							emit    = 1'b1;
							res_d   = '{kind: KIND_PAY_END, value: '0, last: 1'b1};
						end else begin
							phase_d = PH_PDAT;
						end
					end
					PH_PDAT: begin
						items_d = items_d - LEN_BITS'(1);
						if (items_d == '0)
							phase_d = PH_END;
						emit  = 1'b1;
						res_d = '{kind: KIND_PAY_BYTE, value: v[CHR_BITS-1:0], last: 1'b0};
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	assign push = accept && emit;
	assign res  = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= '0;
			magic_len_q  <= MLEN_W'(2);
			phase_q      <= PH_HEADER;
			bif_q        <= '0;
			hl_q         <= HDR_W'(HEADER_BYTES);
			acc_q        <= '0;
			items_q      <= '0;
			midx_q       <= '0;
			meq_q        <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAGIC_WORD:   magic_word_q <= cfg_data;
					CFG_MAGIC_LENGTH: magic_len_q  <= cfg_data[MLEN_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				phase_q <= phase_d;
				bif_q   <= bif_d;
				hl_q    <= hl_d;
				acc_q   <= acc_d;
				items_q <= items_d;
				midx_q  <= midx_d;
				meq_q   <= meq_d;
			end
		end
	end

	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> accept)
		else $error("result pushed without an accepted beat");

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !frame_start && phase_q == PH_IDLE) |-> !push)
		else $error("result produced while idle");

endmodule : lsbse_front
`default_nettype wire

// ===== rtl/lsbse_fifo.sv =====
// short result queue between the parser and the output stage
`default_nettype none
module lsbse_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire lsbse_pkg::res_t      wdata,
	input  wire logic                 pop,
	output lsbse_pkg::res_t           rdata,
	output logic                      empty,
	output logic                      full
);
	import lsbse_pkg::*;

	res_t             ent_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PTR_W'(1);
			if (pop)
				rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue underflow");

endmodule : lsbse_fifo
`default_nettype wire

// ===== rtl/lsbse_back.sv =====
// back end: output register that hands queued results to the downstream side
`default_nettype none
module lsbse_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire lsbse_pkg::res_t  q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output lsbse_pkg::res_t       out_res
);
	import lsbse_pkg::*;

	logic valid_q;
	res_t res_q;

	// refill when the register is empty or its beat leaves this cycle
	assign q_pop     = !q_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= q_data;
	end

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_q)
		else $error("popped result not presented");

endmodule : lsbse_back
`default_nettype wire

// ===== rtl/lsb_stego_payload_extractor.sv =====
// top level of the lsb stego payload extractor
// One carrier beat is taken per clock cycle while in_stall is low. The
// parser in the front end handles each beat in the cycle it is accepted and
// drops at most one result into a four-entry queue; an output register
// drains that queue one beat per cycle while out_stall is low. in_stall
// rises only when the queue is full, so a downstream stall reaches the input
// once five results have backed up, four in the queue and one in the output
// register. A result is held in a queue entry, then in the output register.
// Configuration writes take effect at the next edge and must be made while
// no results are outstanding.
`default_nettype none
module lsb_stego_payload_extractor (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lsbse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lsbse_pkg::MWORD_W-1:0]    cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [lsbse_pkg::CHR_BITS-1:0]   carrier_byte,
	input  wire logic                             frame_start,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [2:0]                            kind,
	output logic [lsbse_pkg::CHR_BITS-1:0]        value,
	output logic                                  last
);
	import lsbse_pkg::*;

	logic accept;
	logic push;
	res_t push_res;
	logic q_pop;
	logic q_empty;
	logic q_full;
	res_t q_data;
	res_t out_res;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	lsbse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.carrier_byte (carrier_byte),
		.frame_start  (frame_start),
		.push         (push),
		.res          (push_res)
	);

	lsbse_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_res),
		.pop    (q_pop),
		.rdata  (q_data),
		.empty  (q_empty),
		.full   (q_full)
	);

	lsbse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign kind  = out_res.kind;
	assign value = out_res.value;
	assign last  = out_res.last;

endmodule : lsb_stego_payload_extractor
`default_nettype wire

// ===== test/tb_lsb_stego_payload_extractor.sv =====
// testbench for the lsb stego payload extractor: directed and random carrier frames
`timescale 1ns / 1ps
module tb_lsb_stego_payload_extractor;
	import lsbse_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BEATS = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int NO_BAD_CHAR = 99;

	typedef enum logic [3:0] {
		P_HDR, P_MAGIC_LEN, P_MAGIC_CHR, P_EXT_LEN, P_EXT_CHR,
		P_PAY_LEN, P_PAY_DATA, P_END, P_DONE
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fs;
	} carrier_beat_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_MAGIC_WORD;
	logic [MWORD_W-1:0]   cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [CHR_BITS-1:0]  carrier_byte = '0;
	logic                 frame_start  = 1'b0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [2:0]           kind;
	logic [CHR_BITS-1:0]  value;
	logic                 last;

	// parser model state and its copy of the registers
	parse_phase_t    ph;
	logic [BIF_W-1:0] bits_in;
	logic [HDR_W-1:0] hdr_left;
	logic [31:0]      shift_reg;
	logic [31:0]      count_left;
	logic [3:0]       sig_idx;
	logic             sig_match;
	logic [63:0]      sig_word;
	logic [3:0]       sig_len;

	carrier_beat_t carrier_q[$];
	res_t          decoded_q[$];
	int            queued_beats = 0;
	int            mismatches = 0;
	logic          in_taken = 1'b0;
	int            in_gap_pct = 0;
	int            out_stall_pct = 0;
	int            hold_req = 0;
	int            hold_seen = 0;
	int            hold_left = 0;

	lsb_stego_payload_extractor DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.carrier_byte(carrier_byte),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.value       (value),
		.last        (last)
	);

	always #10 clk = ~clk;

	task automatic restart_parse();
		ph = P_HDR;
		bits_in = '0;
		hdr_left = HDR_W'(HEADER_BYTES);
		shift_reg = '0;
		count_left = '0;
		sig_idx = '0;
		sig_match = 1'b1;
	endtask

	task automatic note_result(input kind_t k, input logic [7:0] v, input logic l);
		res_t r;
		r.kind = k;
		r.value = v;
		r.last = l;
		decoded_q.push_back(r);
	endtask

	task automatic decode_beat(input logic [7:0] b, input logic fs);
		logic [31:0] v;
		logic [7:0]  want;
		int          need;
		if (fs)
			restart_parse();
		if (ph == P_DONE)
			return;
		// the end marker rides on the beat after the last payload byte
		if (ph == P_END) begin
			ph = P_DONE;
			note_result(KIND_PAY_END, 8'd0, 1'b1);
			return;
		end
		if (ph == P_HDR) begin
			if (hdr_left != 0) begin
				hdr_left = hdr_left - 1'b1;
				if (hdr_left == 0)
					ph = P_MAGIC_LEN;
				return;
			end
			ph = P_MAGIC_LEN;
		end
		shift_reg = {shift_reg[30:0], b[0]};
		bits_in = bits_in + 1'b1;
		need = (ph == P_MAGIC_LEN || ph == P_EXT_LEN || ph == P_PAY_LEN) ? LEN_BITS : CHR_BITS;
		if (int'(bits_in) < need)
			return;
		v = shift_reg;
		shift_reg = '0;
		bits_in = '0;
		case (ph)
			P_MAGIC_LEN: begin
				if (v[31] || v != {28'd0, sig_len} || sig_len > MAGIC_MAX_CHARS) begin
					ph = P_DONE;
					note_result(KIND_MAGIC_BAD, 8'd0, 1'b1);
				end else if (v == 0) begin
					ph = P_EXT_LEN;
					note_result(KIND_MAGIC_OK, 8'd0, 1'b0);
				end else begin
					count_left = v;
					sig_idx = '0;
					sig_match = 1'b1;
					ph = P_MAGIC_CHR;
				end
			end
			P_MAGIC_CHR: begin
				want = sig_word[63 - 8 * int'(sig_idx[2:0]) -: 8];
				if (v[7:0] != want)
					sig_match = 1'b0;
				sig_idx = sig_idx + 1'b1;
				count_left = count_left - 1;
				if (count_left == 0) begin
					if (sig_match) begin
						ph = P_EXT_LEN;
						note_result(KIND_MAGIC_OK, 8'd0, 1'b0);
					end else begin
						ph = P_DONE;
						note_result(KIND_MAGIC_BAD, 8'd0, 1'b1);
					end
				end
			end
			P_EXT_LEN: begin
				count_left = v[31] ? 32'd0 : v;
				ph = (count_left == 0) ? P_PAY_LEN : P_EXT_CHR;
			end
			P_EXT_CHR: begin
				count_left = count_left - 1;
				if (count_left == 0)
					ph = P_PAY_LEN;
				note_result(KIND_EXT_CHAR, v[7:0], 1'b0);
			end
			P_PAY_LEN: begin
				count_left = v[31] ? 32'd0 : v;
				if (count_left == 0) begin
					ph = P_DONE;
					note_result(KIND_PAY_END, 8'd0, 1'b1);
				end else begin
					ph = P_PAY_DATA;
				end
			end
			P_PAY_DATA: begin
				count_left = count_left - 1;
				if (count_left == 0)
					ph = P_END;
				note_result(KIND_PAY_BYTE, v[7:0], 1'b0);
			end
			default: ph = P_DONE;
		endcase
	endtask

	// input beats go out at the falling edge once the previous one was taken
	always @(negedge clk) begin : drive_carrier
		bit give;
		if (arst_n && (!in_valid || in_taken)) begin
			give = carrier_q.size() != 0 && $urandom_range(99) >= in_gap_pct;
			if (give) begin
				in_valid <= 1'b1;
				carrier_byte <= carrier_q[0].data;
				frame_start <= carrier_q[0].fs;
				carrier_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < out_stall_pct;
		end
	end

	always @(posedge clk) begin : watch_ports
		res_t want;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result kind %0d value %h last %b",
					$time, kind, value, last);
			end else begin
				want = decoded_q.pop_front();
				if (kind !== want.kind) begin
					mismatches++;
					$display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
				end
				if (value !== want.value) begin
					mismatches++;
					$display("%0t: value expected %h got %h", $time, want.value, value);
				end
				if (last !== want.last) begin
					mismatches++;
					$display("%0t: last expected %b got %b", $time, want.last, last);
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			decode_beat(carrier_byte, frame_start);
	end

	task automatic push_beat(input logic [7:0] b, input logic fs);
		carrier_beat_t t;
		t.data = b;
		t.fs = fs;
		carrier_q.push_back(t);
		queued_beats++;
	endtask

	// n bits of v, msb first, each in the lsb of a beat with random upper bits
	task automatic push_field(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			push_beat({7'($urandom), v[i]}, 1'b0);
	endtask

	task automatic push_quiet(input int n);
		for (int i = 0; i < n; i++)
			push_beat(8'($urandom), 1'b0);
	endtask

	task automatic push_noise(input int n);
		for (int i = 0; i < n; i++)
			push_beat(8'($urandom), $urandom_range(15) == 0);
	endtask

	task automatic start_frame(input logic fs);
		push_beat(8'($urandom), fs);
		push_quiet(HEADER_BYTES - 1);
	endtask

	task automatic queue_frame(input logic fs, input logic [31:0] mlen, input logic [63:0] chars,
			input int n_chr, input logic [31:0] elen, input int n_ext, input logic [31:0] plen,
			input int n_pay, input int fill, input int n_tail);
		start_frame(fs);
		push_field(mlen, 32);
		for (int i = 0; i < n_chr; i++)
			push_field({24'd0, chars[63 - 8 * i -: 8]}, 8);
		push_field(elen, 32);
		for (int i = 0; i < n_ext; i++)
			push_field($urandom, 8);
		push_field(plen, 32);
		for (int i = 0; i < n_pay; i++)
			push_field((fill < 0) ? $urandom : 32'(fill), 8);
		push_quiet(n_tail);
	endtask

	task automatic queue_rand_frame();
		int          r;
		int          bad_at;
		int          n_pay;
		int          n_sent;
		logic [31:0] mlen;
		logic [31:0] elen;
		logic [31:0] plen;
		r = $urandom_range(99);
		start_frame(1'b1);
		if (r < 6) begin
			push_field($urandom | 32'h8000_0000, 32);
			push_noise($urandom_range(4));
			return;
		end
		if (r < 12) begin
			mlen = r[0] ? {28'd0, sig_len ^ 4'(1 << $urandom_range(3))} : ($urandom >> 1);
			push_field(mlen, 32);
			push_noise($urandom_range(4));
			return;
		end
		push_field({28'd0, sig_len}, 32);
		if (sig_len > MAGIC_MAX_CHARS) begin
			push_noise($urandom_range(4));
			return;
		end
		// now and then one signature character carries a flipped bit
		bad_at = (r < 20 && sig_len != 0) ? $urandom_range(sig_len - 1) : NO_BAD_CHAR;
		for (int i = 0; i < sig_len; i++)
			push_field({24'd0, sig_word[63 - 8 * i -: 8]
				^ ((i == bad_at) ? 8'(1 << $urandom_range(7)) : 8'd0)}, 8);
		if (bad_at != NO_BAD_CHAR) begin
			push_noise($urandom_range(4));
			return;
		end
		elen = ($urandom_range(9) == 0) ? ($urandom | 32'h8000_0000) : 32'($urandom_range(4));
		push_field(elen, 32);
		if (!elen[31])
			for (int i = 0; i < int'(elen); i++)
				push_field($urandom, 8);
		r = $urandom_range(99);
		if (r < 8)
			plen = $urandom | 32'h8000_0000;
		else if (r < 16)
			plen = 32'd0;
		else if (r < 22)
			plen = 32'($urandom_range(24, 16));
		else
			plen = 32'($urandom_range(10, 1));
		push_field(plen, 32);
		n_pay = plen[31] ? 0 : int'(plen);
		n_sent = ($urandom_range(9) == 0 && n_pay != 0) ? $urandom_range(n_pay - 1) : n_pay;
		for (int i = 0; i < n_sent; i++)
			push_field($urandom, 8);
		if (n_sent == n_pay)
			push_noise(1 + $urandom_range(2));
	endtask

	task automatic wait_drained();
		wait (carrier_q.size() == 0 && !in_valid && decoded_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [63:0] word, input logic [3:0] len);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAGIC_WORD;
		cfg_data <= word;
		@(negedge clk);
		cfg_index <= CFG_MAGIC_LENGTH;
		cfg_data <= {60'd0, len};
		@(negedge clk);
		cfg_we <= 1'b0;
		sig_word = word;
		sig_len = len;
	endtask

	initial begin
		int beats_at_start;
		restart_parse();
		sig_word = '0;
		sig_len = 4'd2;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int m = 0; m < 4; m++) begin
			case (m)
				0: begin
					in_gap_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_gap_pct = 52;
					out_stall_pct = 0;
				end
				2: begin
					in_gap_pct = 0;
					out_stall_pct = 52;
				end
				default: begin
					in_gap_pct = 10;
					out_stall_pct = 10;
				end
			endcase
			case (m)
				0: begin
					// reset register values, first frame without a frame start; the next
					// frame start lands right where its end marker would be
					queue_frame(1'b0, 32'd2, 64'd0, 2, 32'd1, 1, 32'd1, 1, -1, 0);
					// negative signature length
					start_frame(1'b1);
					push_field(32'hFFFF_FFFF, 32);
					push_quiet(1);
					// signature length differs from the register
					start_frame(1'b1);
					push_field(32'd3, 32);
					push_quiet(1);
					// first character wrong, second right: both read, then reject
					start_frame(1'b1);
					push_field(32'd2, 32);
					push_field(32'h0100, 16);
					push_quiet(1);
					// negative extension length and zero payload size
					queue_frame(1'b1, 32'd2, 64'd0, 2, 32'h8000_0000, 0, 32'd0, 0, -1, 1);
					// payload cut short by a new frame
					queue_frame(1'b1, 32'd2, 64'd0, 2, 32'd0, 0, 32'd3, 2, -1, 0);
				end
				1: begin
					write_cfg(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
					// restart in the middle of the header
					push_beat(8'($urandom), 1'b1);
					push_quiet(20);
					queue_frame(1'b1, 32'd8, 64'hFFFF_FFFF_FFFF_FFFF, 8, 32'd1, 1, 32'd2, 2,
						8'hFF, 2);
				end
				2: begin
					write_cfg({$urandom, $urandom}, 4'd0);
					queue_frame(1'b1, 32'd0, 64'd0, 0, 32'd0, 0, 32'd1, 1, -1, 2);
				end
				default: begin
					// a length above the character limit can never match
					write_cfg(64'd0, 4'd15);
					start_frame(1'b1);
					push_field(32'd15, 32);
					push_quiet(3);
					wait_drained();
					write_cfg({$urandom, $urandom}, 4'($urandom_range(7)));
					beats_at_start = queued_beats;
					while (queued_beats - beats_at_start < PHASE_BEATS)
						queue_rand_frame();
				end
			endcase
			wait_drained();
		end

		// long receiver hold-off while beats keep coming, so the block backs up
		in_gap_pct = 0;
		out_stall_pct = 0;
		write_cfg({$urandom, $urandom}, 4'd2);
		hold_req = hold_req + 1;
		queue_frame(1'b1, 32'd2, sig_word, 2, 32'd1, 1, 32'd8, 8, -1, 2);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("tb_lsb_stego_payload_extractor: PASS");
		else
			$display("tb_lsb_stego_payload_extractor: FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb_lsb_stego_payload_extractor: FAIL");
		$finish;
	end

endmodule

// ===== lsb_stego_payload_extractor.f =====
rtl/lsbse_pkg.sv
rtl/lsbse_front.sv
rtl/lsbse_fifo.sv
rtl/lsbse_back.sv
rtl/lsb_stego_payload_extractor.sv
test/tb_lsb_stego_payload_extractor.sv
